### design/sgag_pkg.sv
// Shared types and constants of the strided gather address generator.
// Used by sgag_ctrl, sgag_datapath and strided_gather_address_gen; no dependencies.
`default_nettype none

package sgag_pkg;

    localparam int MAX_RANK  = 8;
    localparam int DIM_BITS  = 16;
    localparam int ADDR_BITS = 32;
    localparam int STRIDE_W  = 32;
    localparam int DIM_IDX_W = $clog2(MAX_RANK);
    localparam int RANK_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int CNT_W     = 32;

    // running element total saturates one above the 32-bit range
    localparam int TOTAL_W   = 33;
    localparam int TPROD_W   = TOTAL_W + DIM_BITS;
    localparam int EXPECT_W  = 31;
    localparam int EPROD_W   = EXPECT_W + DIM_BITS;

    localparam logic [TPROD_W-1:0] TOTAL_MAX = TPROD_W'(64'hFFFF_FFFF);
    localparam logic [TOTAL_W-1:0] TOTAL_SAT = TOTAL_W'(64'h1_0000_0000);
    localparam logic [EPROD_W-1:0] EXPECT_MAX = EPROD_W'(64'h7FFF_FFFF);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RANK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STORAGE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_FINISH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic mul;
        logic acc;
        logic finish;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic walk_started;
        logic rank_zero;
        logic dim_zero;
    } t_status;

endpackage

`default_nettype wire

### design/strided_gather_address_gen.sv
// Strided gather address generator: step items give one source/destination offset pair each.
// A step inside a running walk gives its result in the cycle after acceptance, one per cycle
// while the sink takes results. The first step after a load, a register write or a walk's end
// runs a setup pass through the multipliers, a multiply and an accumulate state per dimension
// in use (rank capped at 8). Load items give no result. Synchronous active-low reset clears the
// configuration registers, dimension tables and walk; the block is ready the cycle after reset.
`default_nettype none

module strided_gather_address_gen (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration writes
    input  wire logic                               i_cfg_we,
    input  wire logic [sgag_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sgag_pkg::CFG_W-1:0]         i_cfg_data,
    // input stream
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [55:0]                        i_s_tdata,  // dim_sel, dim_size, dim_stride
    input  wire logic [0:0]                         i_s_tuser,  // func
    // output stream
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic [63:0]                             o_m_tdata,  // src_addr, dst_seq
    output logic                                    o_m_tlast,
    output logic [1:0]                              o_m_tuser   // empty_res, no_copy
);

    sgag_pkg::t_cmd    w_cmd;
    sgag_pkg::t_status w_status;
    logic [sgag_pkg::ADDR_BITS-1:0] w_src;
    logic [sgag_pkg::CNT_W-1:0]     w_dst;
    logic                           w_empty;
    logic                           w_nocopy;

    sgag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_func     (i_s_tuser[0]),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sgag_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_dim_sel    (i_s_tdata[2:0]),
        .i_dim_size   (i_s_tdata[18:3]),
        .i_dim_stride (i_s_tdata[50:19]),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_src_addr   (w_src),
        .o_dst_seq    (w_dst),
        .o_last       (o_m_tlast),
        .o_empty_res  (w_empty),
        .o_no_copy    (w_nocopy)
    );

    assign o_m_tdata = {w_dst, w_src};
    assign o_m_tuser = {w_nocopy, w_empty};

endmodule

`default_nettype wire

### design/sgag_ctrl.sv
// Controller of the strided gather address generator: handshakes and setup sequencing.
// Depends on sgag_pkg; drives the command struct of sgag_datapath.
`default_nettype none

module sgag_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_func,
    output logic                   o_s_tready,
    input  wire logic              i_m_tready,
    output logic                   o_m_tvalid,
    input  wire sgag_pkg::t_status i_status,
    output sgag_pkg::t_cmd         o_cmd
);

    sgag_pkg::t_state r_state;
    sgag_pkg::t_state n_state;
    logic             r_out_valid;
    logic             w_out_free;
    logic             w_accept;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && (r_state == sgag_pkg::S_IDLE) && w_out_free;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgag_pkg::S_IDLE: begin
                if (w_accept && i_func == sgag_pkg::FUNC_STEP && !i_status.walk_started) begin
                    n_state = i_status.rank_zero ? sgag_pkg::S_FINISH : sgag_pkg::S_MUL;
                end
            end
            sgag_pkg::S_MUL:    n_state = sgag_pkg::S_ACC;
            sgag_pkg::S_ACC:    n_state = i_status.dim_zero ? sgag_pkg::S_FINISH
                                                            : sgag_pkg::S_MUL;
            sgag_pkg::S_FINISH: n_state = sgag_pkg::S_EMIT;
            sgag_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_state = sgag_pkg::S_IDLE;
                end
            end
            default:            n_state = sgag_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == sgag_pkg::S_IDLE) && w_out_free;
        o_cmd      = '0;
        unique case (r_state)
            sgag_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_func == sgag_pkg::FUNC_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (i_status.walk_started) begin
                        o_cmd.emit = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                    end
                end
            end
            sgag_pkg::S_MUL:    o_cmd.mul    = 1'b1;
            sgag_pkg::S_ACC:    o_cmd.acc    = 1'b1;
            sgag_pkg::S_FINISH: o_cmd.finish = 1'b1;
            sgag_pkg::S_EMIT:   o_cmd.emit   = w_out_free;
            default:            o_cmd        = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sgag_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // hold the result until the sink takes it
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### design/sgag_datapath.sv
// Datapath of the strided gather address generator: tables, setup pass, odometer walk.
// Depends on sgag_pkg; steered by the command struct from sgag_ctrl.
`default_nettype none

module sgag_datapath (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [sgag_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [sgag_pkg::CFG_W-1:0]             i_cfg_data,
    input  wire logic [sgag_pkg::DIM_IDX_W-1:0]         i_dim_sel,
    input  wire logic [sgag_pkg::DIM_BITS-1:0]          i_dim_size,
    input  wire logic [sgag_pkg::STRIDE_W-1:0]          i_dim_stride,
    input  wire sgag_pkg::t_cmd                         i_cmd,
    output sgag_pkg::t_status                           o_status,
    output logic [sgag_pkg::ADDR_BITS-1:0]              o_src_addr,
    output logic [sgag_pkg::CNT_W-1:0]                  o_dst_seq,
    output logic                                        o_last,
    output logic                                        o_empty_res,
    output logic                                        o_no_copy
);

    localparam int MR = sgag_pkg::MAX_RANK;
    localparam int AW = sgag_pkg::ADDR_BITS;
    localparam int DW = sgag_pkg::DIM_BITS;
    localparam int IW = sgag_pkg::DIM_IDX_W;
    localparam int RW = sgag_pkg::RANK_W;

    // configuration
    logic [RW-1:0]                     r_rank;
    logic [AW-1:0]                     r_base;
    logic [sgag_pkg::CFG_W-1:0]        r_storage;

    // dimension tables and walk state
    logic [DW-1:0]                     r_size   [MR];
    logic [AW-1:0]                     r_stride [MR];
    logic [DW-1:0]                     r_idx    [MR];
    logic [AW-1:0]                     r_delta  [MR];
    logic                              r_walk;
    logic [AW-1:0]                     r_running;
    logic [sgag_pkg::CNT_W-1:0]        r_count;
    logic                              r_flag_nocopy;

    // setup pass
    logic [IW-1:0]                     r_dim;
    logic [sgag_pkg::TOTAL_W-1:0]      r_total;
    logic [sgag_pkg::EXPECT_W-1:0]     r_expect;
    logic [AW-1:0]                     r_wrap;
    logic                              r_empty;
    logic                              r_big;
    logic                              r_contig;
    logic [sgag_pkg::TPROD_W-1:0]      r_prod_total;
    logic [sgag_pkg::EPROD_W-1:0]      r_prod_expect;
    logic [AW-1:0]                     r_prod_wrap;

    logic [RW-1:0]                     w_rank;
    logic [DW-1:0]                     w_sel_size;
    logic [AW-1:0]                     w_sel_stride;
    logic [MR-1:0]                     w_in_use;
    logic [MR-1:0]                     w_at_end;
    logic                              w_last;
    logic [IW-1:0]                     w_carry_dim;
    logic                              w_nocopy;

    assign w_rank = (r_rank > RW'(MR)) ? RW'(MR) : r_rank;
    assign w_sel_size   = r_size[r_dim];
    assign w_sel_stride = r_stride[r_dim];

    assign w_nocopy = !r_empty && r_contig && !r_big && (r_base == '0)
                      && (r_storage == r_total[sgag_pkg::CFG_W-1:0]);

    always_comb begin
        w_carry_dim = '0;
        for (int d = 0; d < MR; d++) begin
            w_in_use[d] = (RW'(d) < w_rank);
            w_at_end[d] = ((DW+1)'(r_idx[d]) + (DW+1)'(1)) == (DW+1)'(r_size[d]);
            // highest dimension in use that has not reached its end
            if (w_in_use[d] && !w_at_end[d]) begin
                w_carry_dim = IW'(d);
            end
        end
    end

    assign w_last = &(w_at_end | ~w_in_use);

    assign o_status.walk_started = r_walk;
    assign o_status.rank_zero    = (w_rank == '0);
    assign o_status.dim_zero     = (r_dim == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank    <= '0;
            r_base    <= '0;
            r_storage <= '0;
            for (int d = 0; d < MR; d++) begin
                r_size[d]   <= '0;
                r_stride[d] <= '0;
                r_idx[d]    <= '0;
            end
            r_walk        <= 1'b0;
            r_running     <= '0;
            r_count       <= '0;
            r_flag_nocopy <= 1'b0;
            r_dim         <= '0;
            r_total       <= '0;
            r_expect      <= '0;
            r_wrap        <= '0;
            r_empty       <= 1'b0;
            r_big         <= 1'b0;
            r_contig      <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_size[i_dim_sel]   <= i_dim_size;
                r_stride[i_dim_sel] <= AW'(i_dim_stride);
                r_walk              <= 1'b0;
            end

            if (i_cmd.start) begin
                r_dim    <= IW'(w_rank - RW'(1));
                r_total  <= sgag_pkg::TOTAL_W'(1);
                r_expect <= sgag_pkg::EXPECT_W'(1);
                r_wrap   <= '0;
                r_empty  <= 1'b0;
                r_big    <= 1'b0;
                r_contig <= 1'b1;
            end

            if (i_cmd.acc) begin
                if (w_sel_size == '0) begin
                    r_empty <= 1'b1;
                end
                // saturate the element total just above the 32-bit range
                if (r_prod_total > sgag_pkg::TOTAL_MAX) begin
                    r_big   <= 1'b1;
                    r_total <= sgag_pkg::TOTAL_SAT;
                end else begin
                    r_total <= r_prod_total[sgag_pkg::TOTAL_W-1:0];
                end
                if (r_contig && w_sel_size > DW'(1)) begin
                    if (w_sel_stride != AW'(r_expect)) begin
                        r_contig <= 1'b0;
                    end else if (r_prod_expect > sgag_pkg::EXPECT_MAX) begin
                        r_contig <= 1'b0;
                    end else begin
                        r_expect <= r_prod_expect[sgag_pkg::EXPECT_W-1:0];
                    end
                end
                r_wrap <= r_wrap + r_prod_wrap;
                r_dim  <= r_dim - IW'(1);
            end

            if (i_cmd.finish) begin
                r_flag_nocopy <= w_nocopy;
                if (!r_empty) begin
                    r_walk    <= 1'b1;
                    r_running <= r_base;
                    r_count   <= '0;
                    for (int d = 0; d < MR; d++) begin
                        r_idx[d] <= '0;
                    end
                end
            end

            if (i_cmd.emit && r_walk) begin
                if (w_last) begin
                    r_walk <= 1'b0;
                end else begin
                    // advance the odometer: bump the carry dimension, clear those inside it
                    for (int d = 0; d < MR; d++) begin
                        if (IW'(d) == w_carry_dim) begin
                            r_idx[d] <= r_idx[d] + DW'(1);
                        end else if (IW'(d) > w_carry_dim) begin
                            r_idx[d] <= '0;
                        end
                    end
                    r_count   <= r_count + sgag_pkg::CNT_W'(1);
                    r_running <= r_running + r_delta[w_carry_dim];
                end
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sgag_pkg::CFG_RANK: begin
                        r_rank <= i_cfg_data[RW-1:0];
                        r_walk <= 1'b0;
                    end
                    sgag_pkg::CFG_BASE: begin
                        r_base <= AW'(i_cfg_data);
                        r_walk <= 1'b0;
                    end
                    sgag_pkg::CFG_STORAGE: begin
                        r_storage <= i_cfg_data;
                        r_walk    <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // products and source-offset deltas of the setup pass, and the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_total  <= sgag_pkg::TPROD_W'(r_total) * sgag_pkg::TPROD_W'(w_sel_size);
            r_prod_expect <= sgag_pkg::EPROD_W'(r_expect) * sgag_pkg::EPROD_W'(w_sel_size);
            r_prod_wrap   <= (AW'(w_sel_size) - AW'(1)) * w_sel_stride;
        end
        if (i_cmd.acc) begin
            // step from the end of all inner dimensions into the next index of this one
            r_delta[r_dim] <= w_sel_stride - r_wrap;
        end
        if (i_cmd.emit) begin
            if (r_walk) begin
                o_src_addr  <= r_running;
                o_dst_seq   <= r_count;
                o_last      <= w_last;
                o_empty_res <= 1'b0;
                o_no_copy   <= r_flag_nocopy;
            end else begin
                o_src_addr  <= '0;
                o_dst_seq   <= '0;
                o_last      <= 1'b1;
                o_empty_res <= 1'b1;
                o_no_copy   <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
